FILE: design/tmpt_pkg.sv
// Shared types and constants for the touch majority publish throttle.
// No dependencies; used by the controller, the datapath and the top level.
package tmpt_pkg;

    localparam int unsigned MASK_W   = 35;   // touch and publish mask field width
    localparam int unsigned TIME_W   = 32;   // microsecond time width
    localparam int unsigned MS_W     = 23;   // width of now_us / 1000
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned HZ_W     = 16;
    localparam int unsigned DIV_STEPS = 20;  // restoring steps for 1e6 / hz
    localparam int unsigned STEP_W   = 5;

    // now_us / 1000 == (now_us * DIV_MAGIC) >> DIV_SHIFT for all 32-bit now_us
    localparam logic [28:0] DIV_MAGIC = 29'd274877907;
    localparam int unsigned DIV_SHIFT = 38;
    localparam logic [DIV_STEPS-1:0] US_PER_S = 20'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_MS   = 3'd0,
        CFG_EXTRA_SENDS = 3'd1,
        CFG_RATE_HZ     = 3'd2,
        CFG_RATE_ON     = 3'd3,
        CFG_CHANGE_ONLY = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVIDE,
        ST_STORE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic take;     // capture input item
        logic ms;       // register now_ms from the reciprocal product
        logic div;      // one restoring step of the interval divider
        logic store;    // write the slot ring, clear vote counters
        logic scan;     // read next slot
        logic decide;   // evaluate, update send state, load output register
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic scan_last;
        logic no_window;
        logic out_free;
    } t_status;

endpackage

FILE: design/touch_majority_publish_throttle.sv
// Touch majority publish throttle: top level.
// One tick item in on the slave stream, one result item out on the master stream.
// Configuration registers are written over a valid/ready channel, index 0..4:
// aggregation window ms, extra send count, rate limit Hz, rate limit on,
// send on change only. The write port is always ready.
// Steps: a multiply for now_us / 1000, restoring steps for the 1e6 / Hz
// interval (the slot index settles alongside), a slot write, the vote scan
// (skipped with a zero window), then evaluate. One item at a time: a tick is
// taken only after the one before has loaded the output register.
// The result sits in an output register; the next tick is taken while it
// waits. If the receiver stalls, the following result waits in the evaluate
// step and no further tick is taken until the register frees.
// Reset (synchronous, active low) clears configuration, slot valid bits and
// all send state; slot contents are left as they are.
module touch_majority_publish_throttle #(
    parameter int SLOT_COUNT = 16,
    parameter int AREA_BITS  = 35
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // now_us[31:0], area mask[66:32], zero pad
    input  logic        s_axis_tuser,   // link_ready
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // publish_mask[34:0], zero pad
    output logic [1:0]  m_axis_tuser,   // send_now, rate_held
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tmpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tmpt_pkg::t_cmd    cmd;
    tmpt_pkg::t_status status;
    logic              idle;
    logic              send_now;
    logic              rate_held;
    logic [tmpt_pkg::MASK_W-1:0] publish_mask;

    assign s_axis_tready = idle;
    assign o_cfg_ready   = 1'b1;

    tmpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (s_axis_tvalid),
        .i_status (status),
        .o_idle   (idle),
        .o_cmd    (cmd)
    );

    tmpt_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .AREA_BITS  (AREA_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_now_us       (s_axis_tdata[31:0]),
        .i_area_mask    (s_axis_tdata[66:32]),
        .i_link_ready   (s_axis_tuser),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_take     (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_send_now     (send_now),
        .o_publish_mask (publish_mask),
        .o_rate_held    (rate_held)
    );

    assign m_axis_tdata = {5'b0, publish_mask};
    assign m_axis_tuser = {rate_held, send_now};

endmodule

FILE: design/tmpt_ctrl.sv
// Sequencer for the touch majority publish throttle.
// Depends on tmpt_pkg; drives the datapath by command struct.
module tmpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  tmpt_pkg::t_status i_status,
    output logic              o_idle,
    output tmpt_pkg::t_cmd    o_cmd
);

    tmpt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        unique case (r_state)
            tmpt_pkg::ST_IDLE: begin
                o_idle = 1'b1;
                if (i_take) begin
                    o_cmd.take = 1'b1;
                    n_state    = tmpt_pkg::ST_MUL;
                end
            end
            tmpt_pkg::ST_MUL: begin
                o_cmd.ms = 1'b1;
                n_state  = tmpt_pkg::ST_DIVIDE;
            end
            tmpt_pkg::ST_DIVIDE: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = tmpt_pkg::ST_STORE;
                end
            end
            tmpt_pkg::ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state = i_status.no_window ? tmpt_pkg::ST_DECIDE : tmpt_pkg::ST_SCAN;
            end
            tmpt_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = tmpt_pkg::ST_DRAIN;
                end
            end
            tmpt_pkg::ST_DRAIN: begin
                // last read data is counted this cycle
                n_state = tmpt_pkg::ST_DECIDE;
            end
            tmpt_pkg::ST_DECIDE: begin
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = tmpt_pkg::ST_IDLE;
                end
            end
            default: n_state = tmpt_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: design/tmpt_datapath.sv
// Datapath: ms conversion, slot ring, majority vote lanes, send rule, output register.
// Depends on tmpt_pkg; sequenced by tmpt_ctrl.
module tmpt_datapath #(
    parameter int SLOT_COUNT = 16,
    parameter int AREA_BITS  = 35
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tmpt_pkg::t_cmd                       i_cmd,
    output tmpt_pkg::t_status                    o_status,
    // input item
    input  logic [tmpt_pkg::TIME_W-1:0]          i_now_us,
    input  logic [tmpt_pkg::MASK_W-1:0]          i_area_mask,
    input  logic                                 i_link_ready,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [tmpt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tmpt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // result item
    input  logic                                 i_out_take,
    output logic                                 o_out_valid,
    output logic                                 o_send_now,
    output logic [tmpt_pkg::MASK_W-1:0]          o_publish_mask,
    output logic                                 o_rate_held
);

    localparam int L  = (AREA_BITS < 35) ? AREA_BITS : 35;
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int VW = $clog2(SLOT_COUNT + 1);
    localparam int MW = tmpt_pkg::MS_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
    localparam int LOG_D     = $clog2(SLOT_COUNT);
    localparam int MOD_SHIFT = MW + LOG_D;
    localparam int PW        = MOD_SHIFT + MW;
    localparam logic [MW:0] MOD_MAGIC =
        (MW+1)'(((64'd1 << MOD_SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));
    localparam logic [MW-1:0] SLOTS_M = MW'(SLOT_COUNT);

    // configuration registers
    logic [7:0]                    r_window;
    logic [7:0]                    r_extra;
    logic [tmpt_pkg::HZ_W-1:0]     r_hz;
    logic                          r_rate_on;
    logic                          r_change_only;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= '0;
            r_extra       <= '0;
            r_hz          <= '0;
            r_rate_on     <= 1'b0;
            r_change_only <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tmpt_pkg::CFG_WINDOW_MS:   r_window      <= i_cfg_data[7:0];
                tmpt_pkg::CFG_EXTRA_SENDS: r_extra       <= i_cfg_data[7:0];
                tmpt_pkg::CFG_RATE_HZ:     r_hz          <= i_cfg_data;
                tmpt_pkg::CFG_RATE_ON:     r_rate_on     <= i_cfg_data[0];
                tmpt_pkg::CFG_CHANGE_ONLY: r_change_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [tmpt_pkg::TIME_W-1:0] r_now;
    logic [L-1:0]                r_sample;
    logic                        r_ready;
    logic [MW-1:0]               r_now_ms;
    logic [60:0]                 prod;

    assign prod = 61'(r_now) * 61'(tmpt_pkg::DIV_MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_now    <= i_now_us;
            r_sample <= i_area_mask[L-1:0];
            r_ready  <= i_link_ready;
        end
        if (i_cmd.ms) begin
            r_now_ms <= prod[tmpt_pkg::DIV_SHIFT +: MW];
        end
    end

    // restoring divider for 1e6 / hz, one bit a step
    logic [tmpt_pkg::STEP_W-1:0] r_step;
    logic [tmpt_pkg::HZ_W:0]     r_hrem;
    logic [MW-1:0]               r_gap;
    logic [tmpt_pkg::HZ_W:0]     hrem_sh;
    logic                        hq;
    logic [tmpt_pkg::STEP_W-1:0] bit_idx;

    assign bit_idx = tmpt_pkg::STEP_W'(tmpt_pkg::DIV_STEPS - 1) - r_step;
    assign hrem_sh = {r_hrem[tmpt_pkg::HZ_W-1:0], tmpt_pkg::US_PER_S[bit_idx]};
    assign hq      = (hrem_sh >= {1'b0, r_hz});

    always_ff @(posedge i_clk) begin
        if (i_cmd.ms) begin
            r_step <= '0;
            r_hrem <= '0;
            r_gap  <= '0;
        end else if (i_cmd.div) begin
            r_step <= r_step + 1'b1;
            r_hrem <= hq ? hrem_sh - {1'b0, r_hz} : hrem_sh;
            r_gap  <= {r_gap[MW-2:0], hq};
        end
    end

    // slot index: now_ms mod SLOT_COUNT by reciprocal multiply; the quotient
    // lands on the first divider step, the remainder is right from the second
    logic [PW-1:0] qprod;
    logic [MW-1:0] r_quot;
    logic [MW-1:0] rem_full;
    logic [SW-1:0] r_slot;

    assign qprod    = PW'(r_now_ms) * PW'(MOD_MAGIC);
    assign rem_full = r_now_ms - r_quot * SLOTS_M;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div) begin
            r_quot <= qprod[MOD_SHIFT +: MW];
            r_slot <= rem_full[SW-1:0];
        end
    end

    // slot ring
    logic [MW+L-1:0]       mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_slot_valid;
    logic [SW-1:0]         slot;
    logic [SW-1:0]         r_scan_idx;
    logic [MW+L-1:0]       r_rd_data;
    logic                  r_rd_sv;
    logic                  r_rd_vld;

    assign slot = r_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[slot] <= {r_now_ms, r_sample};
        end
        if (i_cmd.scan) begin
            r_rd_data <= mem[r_scan_idx];
            r_rd_sv   <= r_slot_valid[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_slot_valid[slot] <= 1'b1;
            end
            r_rd_vld <= i_cmd.scan;
        end
    end

    // vote lanes
    logic [VW-1:0]   r_votes [L];
    logic [VW-1:0]   r_count;
    logic [MW:0]     age;
    logic            hit;
    logic [MW-1:0]   rd_time;
    logic [L-1:0]    rd_mask;

    assign rd_time = r_rd_data[L +: MW];
    assign rd_mask = r_rd_data[L-1:0];
    assign age     = {1'b0, r_now_ms} - {1'b0, rd_time};
    // slot newer than now wraps to a huge age and never counts
    assign hit     = r_rd_vld && r_rd_sv && !age[MW] && (age[MW-1:0] <= MW'(r_window));

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_scan_idx <= '0;
            r_count    <= '0;
            for (int b = 0; b < L; b++) begin
                r_votes[b] <= '0;
            end
        end else begin
            if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (hit) begin
                r_count <= r_count + 1'b1;
                for (int b = 0; b < L; b++) begin
                    r_votes[b] <= r_votes[b] + VW'(rd_mask[b]);
                end
            end
        end
    end

    // send state
    logic [L-1:0] r_prev_agg;
    logic         r_agg_valid;
    logic [L-1:0] r_sent_mask;
    logic         r_sent_valid;
    logic [tmpt_pkg::TIME_W-1:0] r_last_send;
    logic [7:0]   r_repeats;

    logic [tmpt_pkg::TIME_W-1:0] since;
    logic         held;
    logic [L-1:0] maj;
    logic [L-1:0] pub;
    logic         use_maj;
    logic         changed;
    logic         send;
    logic [tmpt_pkg::MASK_W-1:0] pub_full;

    assign since = r_now - r_last_send;
    assign held  = r_rate_on && (r_hz != '0) && (r_last_send != '0) && (r_gap != '0)
                   && (since < tmpt_pkg::TIME_W'(r_gap));

    always_comb begin
        for (int b = 0; b < L; b++) begin
            maj[b] = ({r_votes[b], 1'b0} > {1'b0, r_count})
                     || (({r_votes[b], 1'b0} == {1'b0, r_count}) && r_agg_valid
                         && r_prev_agg[b]);
        end
        use_maj = 1'b0;
        if (r_window == '0) begin
            pub = r_sample;
        end else if (r_count == '0) begin
            pub = r_agg_valid ? r_prev_agg : r_sample;
        end else begin
            pub     = maj;
            use_maj = 1'b1;
        end
        changed  = !r_sent_valid || (pub != r_sent_mask);
        send     = (!r_change_only || changed || (r_repeats != '0)) && r_ready;
        pub_full = '0;
        pub_full[L-1:0] = pub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_agg   <= '0;
            r_agg_valid  <= 1'b0;
            r_sent_mask  <= '0;
            r_sent_valid <= 1'b0;
            r_last_send  <= '0;
            r_repeats    <= '0;
        end else if (i_cmd.decide && !held) begin
            if (use_maj) begin
                r_prev_agg  <= maj;
                r_agg_valid <= 1'b1;
            end
            if (send) begin
                if (changed) begin
                    r_repeats <= r_extra;
                end else if (r_change_only && (r_repeats != '0)) begin
                    r_repeats <= r_repeats - 1'b1;
                end
                r_sent_mask  <= pub;
                r_sent_valid <= 1'b1;
                if (r_rate_on) begin
                    r_last_send <= r_now;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            o_out_valid <= 1'b1;
        end else if (i_out_take) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            o_send_now     <= !held && send;
            o_publish_mask <= held ? '0 : pub_full;
            o_rate_held    <= held;
        end
    end

    assign o_status.div_last  = (r_step == tmpt_pkg::STEP_W'(tmpt_pkg::DIV_STEPS - 1));
    assign o_status.scan_last = (r_scan_idx == LAST_SLOT);
    assign o_status.no_window = (r_window == '0);
    assign o_status.out_free  = !o_out_valid || i_out_take;

endmodule

FILE: bench/touch_majority_publish_throttle_tb.sv
// Self-checking bench for touch_majority_publish_throttle: ticks go in bursts on the
// slave stream, and results are checked against a predictor held in a scoreboard class.
// Depends on tmpt_pkg and the top level only.
module touch_majority_publish_throttle_tb;

    localparam int SLOTS = 16;
    localparam int NBITS = 35;

    typedef struct {
        logic             send;
        logic [NBITS-1:0] mask;
        logic             held;
    } t_publish;

    class publish_scoreboard;
        logic [7:0]       vote_win;
        logic [7:0]       extra_sends;
        logic [15:0]      rate_hz;
        logic             rate_on;
        logic             change_only;
        logic [31:0]      ring_ms[SLOTS];
        logic [NBITS-1:0] ring_mask[SLOTS];
        logic             ring_ok[SLOTS];
        logic [NBITS-1:0] latest;
        logic [NBITS-1:0] prev_agg;
        logic             agg_ok;
        logic [NBITS-1:0] sent;
        logic             sent_ok;
        logic [31:0]      last_send_us;
        logic [7:0]       repeats;
        t_publish         pending[$];
        int               errors;

        function new();
            vote_win = 0; extra_sends = 0; rate_hz = 0; rate_on = 0; change_only = 0;
            foreach (ring_ok[i]) ring_ok[i] = 0;
            latest = 0; prev_agg = 0; agg_ok = 0; sent = 0; sent_ok = 0;
            last_send_us = 0; repeats = 0; errors = 0;
        endfunction

        function void set_reg(tmpt_pkg::t_cfg_idx idx, logic [15:0] val);
            case (idx)
                tmpt_pkg::CFG_WINDOW_MS:   vote_win    = val[7:0];
                tmpt_pkg::CFG_EXTRA_SENDS: extra_sends = val[7:0];
                tmpt_pkg::CFG_RATE_HZ:     rate_hz     = val;
                tmpt_pkg::CFG_RATE_ON:     rate_on     = val[0];
                tmpt_pkg::CFG_CHANGE_ONLY: change_only = val[0];
                default: ;
            endcase
        endfunction

        function logic [NBITS-1:0] vote(logic [31:0] now_ms);
            int unsigned      votes[NBITS];
            int unsigned      count;
            logic [NBITS-1:0] res;
            if (vote_win == 0) return latest;
            count = 0;
            res = '0;
            foreach (votes[b]) votes[b] = 0;
            for (int s = 0; s < SLOTS; s++) begin
                if (ring_ok[s] && (now_ms - ring_ms[s]) <= {24'd0, vote_win}) begin
                    count++;
                    for (int b = 0; b < NBITS; b++) votes[b] += ring_mask[s][b];
                end
            end
            if (count == 0) return agg_ok ? prev_agg : latest;
            for (int b = 0; b < NBITS; b++) begin
                if (votes[b] * 2 > count || (votes[b] * 2 == count && agg_ok && prev_agg[b]))
                    res[b] = 1'b1;
            end
            prev_agg = res;
            agg_ok = 1;
            return res;
        endfunction

        function void note_tick(logic [31:0] now_us, logic [NBITS-1:0] mask, logic ready);
            logic [31:0] now_ms;
            logic [31:0] gap;
            int          slot;
            t_publish    p;
            logic        changed;
            now_ms = now_us / 1000;
            slot = now_ms % SLOTS;
            ring_ms[slot] = now_ms;
            ring_mask[slot] = mask;
            ring_ok[slot] = 1;
            latest = mask;
            gap = (rate_hz != 0) ? 32'd1000000 / rate_hz : 0;
            if (rate_on && rate_hz != 0 && last_send_us != 0 && gap != 0
                    && (now_us - last_send_us) < gap) begin
                p.send = 0; p.mask = '0; p.held = 1;
                pending.push_back(p);
                return;
            end
            p.mask = vote(now_ms);
            p.held = 0;
            changed = !sent_ok || p.mask != sent;
            p.send = (!change_only || changed || repeats != 0) && ready;
            if (p.send) begin
                if (changed) repeats = extra_sends;
                else if (change_only && repeats != 0) repeats--;
                sent = p.mask;
                sent_ok = 1;
                if (rate_on) last_send_us = now_us;
            end
            pending.push_back(p);
        endfunction

        function void check_publish(logic send, logic [NBITS-1:0] mask, logic held);
            t_publish p;
            if (pending.size() == 0) begin
                $error("result with nothing expected: send_now=%0b publish_mask=%h", send, mask);
                errors++;
                return;
            end
            p = pending.pop_front();
            if (send !== p.send) begin
                $error("send_now expected %0b actual %0b", p.send, send); errors++;
            end
            if (mask !== p.mask) begin
                $error("publish_mask expected %h actual %h", p.mask, mask); errors++;
            end
            if (held !== p.held) begin
                $error("rate_held expected %0b actual %0b", p.held, held); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [tmpt_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tmpt_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    touch_majority_publish_throttle uut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    publish_scoreboard sb = new();
    logic [31:0] tick_us = 0;
    int          burst_left = 0;
    bit          hold_off = 0;
    int          stall_mode = 0;
    int          mode_cycles = 0;
    int          hold_cycles = 0;

    // receiver: checks results and stalls by pattern, or holds off on request
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_publish(m_axis_tuser[0], m_axis_tdata[NBITS-1:0], m_axis_tuser[1]);
        if (hold_off && hold_cycles == 0) hold_cycles = 500;
        if (hold_cycles > 0) begin
            hold_cycles--;
            if (hold_cycles == 0) hold_off = 0;
            m_axis_tready <= 0;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_cycles = $urandom_range(20, 200);
            end
            mode_cycles--;
            case (stall_mode)
                0: m_axis_tready <= 1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    task automatic cfg_write(tmpt_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    task automatic set_all(int win, int extra, int hz, int on, int chg);
        cfg_write(tmpt_pkg::CFG_WINDOW_MS, 16'(win));
        cfg_write(tmpt_pkg::CFG_EXTRA_SENDS, 16'(extra));
        cfg_write(tmpt_pkg::CFG_RATE_HZ, 16'(hz));
        cfg_write(tmpt_pkg::CFG_RATE_ON, 16'(on));
        cfg_write(tmpt_pkg::CFG_CHANGE_ONLY, 16'(chg));
        @(posedge i_clk);
    endtask

    task automatic push_tick(logic [31:0] now_us, logic [NBITS-1:0] mask, logic ready);
        if (burst_left == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(0, 60)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {5'd0, mask, now_us};
        s_axis_tuser  <= ready;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(now_us, mask, ready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [NBITS-1:0] rand_mask();
        return NBITS'({$urandom, $urandom});
    endfunction

    initial begin : timeout
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [NBITS-1:0] base;
        logic [NBITS-1:0] m;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, extremes, link not ready, wrap, send at time zero
        push_tick(0, '0, 1);
        push_tick(1, '1, 1);
        push_tick(2, '1, 0);
        push_tick(32'hFFFF_FFFF, '1, 1);
        drain();
        set_all(3, 2, 1000, 1, 1);
        push_tick(0, 35'h5_5555_5555, 1);       // send at zero leaves next tick free
        push_tick(100, 35'h5_5555_5555, 1);
        push_tick(700, 35'h2_AAAA_AAAA, 1);     // within interval: held
        push_tick(2100, 35'h2_AAAA_AAAA, 1);
        push_tick(3200, 35'h2_AAAA_AAAA, 1);    // unchanged mask: sent again as an extra send
        push_tick(4300, 35'h2_AAAA_AAAA, 0);
        push_tick(5400, 35'h2_AAAA_AAAA, 1);
        push_tick(6500, 35'h2_AAAA_AAAA, 1);
        push_tick(7600, 35'h2_AAAA_AAAA, 1);
        push_tick(8700, 35'h2_AAAA_AAAA, 1);
        drain();
        set_all(255, 255, 65535, 1, 0);
        push_tick(32'hFFFF_F000, '1, 1);
        push_tick(32'hFFFF_FF00, '0, 1);
        push_tick(32'h0000_0100, '0, 1);        // time wrapped: older slots drop out
        push_tick(32'h0000_2000, '1, 1);
        drain();
        set_all(0, 0, 1, 1, 1);
        push_tick(5000, '1, 1);
        push_tick(6000, '0, 1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_all(0, 0, 0, 0, 0);
                1: set_all(4, 3, 0, 1, 1);
                2: set_all(15, 1, 500, 1, 1);
                3: set_all(255, 255, 65535, 1, 1);
                4: set_all(8, 0, 2000, 0, 0);
                5: set_all(1, 5, 1, 1, 0);
                default: set_all($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 65535), $urandom_range(0, 1),
                                 $urandom_range(0, 1));
            endcase
            base = rand_mask();
            tick_us = $urandom;
            for (int n = 0; n < 75; n++) begin
                if (phase == 3 && n == 20) hold_off = 1;
                if ($urandom_range(0, 15) == 0) base = rand_mask();
                case ($urandom_range(0, 9))
                    0: m = rand_mask();
                    1: m = $urandom_range(0, 1) ? '1 : '0;
                    default: m = base ^ (NBITS'(1) << $urandom_range(0, NBITS - 1))
                                 & {NBITS{$urandom_range(0, 1) == 1}};
                endcase
                if ($urandom_range(0, 30) == 0) tick_us = $urandom;
                else tick_us = tick_us + $urandom_range(0, 2500);
                push_tick(tick_us, m, $urandom_range(0, 4) != 0);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
